[rtl/core/crc16_packet_deframer_top_assert.svh]
// ============================================================================
// Assertion macros for the CRC-16 packet deframer
// Shared helpers that clock every property on clk and disable it in reset.
// ============================================================================
`ifndef CRC16_PACKET_DEFRAMER_TOP_ASSERT_SVH
`define CRC16_PACKET_DEFRAMER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRCDF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRCDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/crcdf_pkg.sv]
// ============================================================================
// CRC-16 packet deframer package
// Widths, result codes, register indexes, control structs and the CRC step.
// ============================================================================
package crcdf_pkg;

    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int LEN_W     = 7;
    localparam int POS_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CRC_W     = 16;

    localparam int MAX_LEN_DEF = 64;

    localparam logic [CRC_W-1:0]  CRC_SEED = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY = 16'hA001;
    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h55;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 1'd1;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_DATA     = 2'd0;
    localparam kind_t KIND_EMPTY    = 2'd1;
    localparam kind_t KIND_CRC_ERR  = 2'd2;
    localparam kind_t KIND_TOO_LONG = 2'd3;

    typedef struct packed {
        logic  addr_load;
        logic  len_load;
        logic  data_store;
        logic  rd_clear;
        logic  rd_issue;
        logic  rd_next;
        logic  out_load;
        logic  out_from_ram;
        kind_t out_kind;
    } cmd_t;

    typedef struct packed {
        logic hit_first;
        logic hit_second;
        logic len_too_long;
        logic len_zero;
        logic data_done;
        logic crc_lo_ok;
        logic crc_hi_ok;
        logic pkt_len_zero;
        logic rd_last;
        logic out_busy;
        logic out_free;
    } sts_t;

    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] c,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] r;
        r = c ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < 8; k++)
        begin
            if (r[0])
            begin
                r = (r >> 1) ^ CRC_POLY;
            end
            else
            begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

endpackage

[rtl/core/crcdf_in_if.sv]
// ============================================================================
// Receive byte channel
// Carries one received serial byte per request.
// ============================================================================
interface crcdf_in_if;
    logic                          valid;
    logic                          ready;
    logic [crcdf_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/core/crcdf_out_if.sv]
// ============================================================================
// Result channel
// Carries one deframer result per request.
// ============================================================================
interface crcdf_out_if;
    logic                          valid;
    logic                          ready;
    logic [crcdf_pkg::KIND_W-1:0]  kind;
    logic [crcdf_pkg::BYTE_W-1:0]  address;
    logic [crcdf_pkg::LEN_W-1:0]   length;
    logic [crcdf_pkg::POS_W-1:0]   position;
    logic [crcdf_pkg::BYTE_W-1:0]  payload_byte;
    logic                          last;

    modport source (output valid, output kind, output address, output length,
                    output position, output payload_byte, output last, input ready);
    modport sink   (input valid, input kind, input address, input length,
                    input position, input payload_byte, input last, output ready);
endinterface

[rtl/core/crcdf_cfg_if.sv]
// ============================================================================
// Configuration write channel
// Carries a register index and write data per request.
// ============================================================================
interface crcdf_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [crcdf_pkg::CFG_IDX_W-1:0] index;
    logic [crcdf_pkg::BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/crc16_packet_deframer_top.sv]
// ============================================================================
// CRC-16 packet deframer
// Hunts for a two-byte sync header, collects address, length and payload,
// checks a CRC-16/MODBUS trailer and emits payload bytes or one status result.
// ============================================================================
// Received bytes are taken at one per clock while hunting, reading the header,
// address and payload. The length byte and the two CRC bytes are taken once the
// result register is empty, since each of them may produce a result. A good
// packet is then read out of the payload RAM one byte at a time, each byte by a
// registered RAM read and then a load of the result register, which waits while
// the result channel stalls; no byte is taken during this readout. Sync
// registers may be written at any time the block is idle; the configuration
// channel is always ready.
module crc16_packet_deframer_top #(
    parameter int MAX_LEN = crcdf_pkg::MAX_LEN_DEF
) (
    input logic         clk,
    input logic         rst_n,
    crcdf_in_if.sink    rx,
    crcdf_out_if.source res,
    crcdf_cfg_if.sink   cfg
);
    import crcdf_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic rx_ready;

    assign cfg.ready = 1'b1;
    assign rx.ready  = rx_ready;

    crcdf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (rx_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    crcdf_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .rx_byte          (rx.rx_byte),
        .cfg_write        (cfg.valid),
        .cfg_index        (cfg.index),
        .cfg_data         (cfg.data),
        .cmd              (cmd),
        .sts              (sts),
        .out_ready        (res.ready),
        .out_valid        (res.valid),
        .out_kind         (res.kind),
        .out_address      (res.address),
        .out_length       (res.length),
        .out_position     (res.position),
        .out_payload_byte (res.payload_byte),
        .out_last         (res.last)
    );

endmodule

[rtl/core/crcdf_ram.sv]
// ============================================================================
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module crcdf_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/crcdf_dp.sv]
// ============================================================================
// CRC-16 packet deframer datapath
// Sync registers, packet fields, running CRC, payload store and result stage.
// ============================================================================
module crcdf_dp #(
    parameter int MAX_LEN = crcdf_pkg::MAX_LEN_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [crcdf_pkg::BYTE_W-1:0]    rx_byte,
    input  logic                            cfg_write,
    input  logic [crcdf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [crcdf_pkg::BYTE_W-1:0]    cfg_data,
    input  crcdf_pkg::cmd_t                 cmd,
    output crcdf_pkg::sts_t                 sts,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [crcdf_pkg::KIND_W-1:0]    out_kind,
    output logic [crcdf_pkg::BYTE_W-1:0]    out_address,
    output logic [crcdf_pkg::LEN_W-1:0]     out_length,
    output logic [crcdf_pkg::POS_W-1:0]     out_position,
    output logic [crcdf_pkg::BYTE_W-1:0]    out_payload_byte,
    output logic                            out_last
);
    import crcdf_pkg::*;

    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic [BYTE_W-1:0] header_first_reg;
    logic [BYTE_W-1:0] header_second_reg;
    logic [BYTE_W-1:0] addr_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  fill_reg;
    logic [CRC_W-1:0]  crc_reg;
    logic [CRC_W-1:0]  crc_next;
    logic [ADDR_W-1:0] rd_idx_reg;
    logic [BYTE_W-1:0] ram_rdata;
    logic [LEN_W-1:0]  fill_inc;
    logic [LEN_W-1:0]  rd_inc;

    logic              out_valid_reg;
    kind_t             out_kind_reg;
    logic [BYTE_W-1:0] out_address_reg;
    logic [LEN_W-1:0]  out_length_reg;
    logic [POS_W-1:0]  out_position_reg;
    logic [BYTE_W-1:0] out_payload_reg;
    logic              out_last_reg;

    assign fill_inc = fill_reg + LEN_W'(1);
    assign rd_inc   = LEN_W'(rd_idx_reg) + LEN_W'(1);
    assign crc_next = crc_feed(cmd.addr_load ? CRC_SEED : crc_reg, rx_byte);

    always_comb
    begin
        sts.hit_first    = (rx_byte == header_first_reg);
        sts.hit_second   = (rx_byte == header_second_reg);
        sts.len_too_long = (rx_byte > BYTE_W'(MAX_LEN));
        sts.len_zero     = (rx_byte == '0);
        sts.data_done    = (fill_inc >= len_reg);
        sts.crc_lo_ok    = (rx_byte == crc_reg[7:0]);
        sts.crc_hi_ok    = (rx_byte == crc_reg[15:8]);
        sts.pkt_len_zero = (len_reg == '0);
        sts.rd_last      = (rd_inc == len_reg);
        sts.out_busy     = out_valid_reg;
        sts.out_free     = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg  <= HEADER_FIRST_RST;
            header_second_reg <= HEADER_SECOND_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_HEADER_FIRST:  header_first_reg  <= cfg_data;
                REG_HEADER_SECOND: header_second_reg <= cfg_data;
                default:           header_first_reg  <= header_first_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg   <= '0;
            len_reg    <= '0;
            fill_reg   <= '0;
            crc_reg    <= CRC_SEED;
            rd_idx_reg <= '0;
        end
        else
        begin
            if (cmd.addr_load)
            begin
                addr_reg <= rx_byte;
                crc_reg  <= crc_next;
            end
            if (cmd.len_load)
            begin
                len_reg  <= rx_byte[LEN_W-1:0];
                fill_reg <= '0;
                crc_reg  <= crc_next;
            end
            if (cmd.data_store)
            begin
                fill_reg <= fill_inc;
                crc_reg  <= crc_next;
            end
            if (cmd.rd_clear)
            begin
                rd_idx_reg <= '0;
            end
            else if (cmd.rd_next)
            begin
                rd_idx_reg <= rd_idx_reg + ADDR_W'(1);
            end
        end
    end

    crcdf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_LEN)
    ) u_store (
        .clk   (clk),
        .we    (cmd.data_store),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (rx_byte),
        .re    (cmd.rd_issue),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_address_reg <= addr_reg;
            if (cmd.out_from_ram)
            begin
                out_kind_reg     <= KIND_DATA;
                out_length_reg   <= len_reg;
                out_position_reg <= POS_W'(rd_idx_reg);
                out_payload_reg  <= ram_rdata;
                out_last_reg     <= sts.rd_last;
            end
            else
            begin
                out_kind_reg     <= cmd.out_kind;
                out_length_reg   <= '0;
                out_position_reg <= '0;
                out_payload_reg  <= '0;
                out_last_reg     <= 1'b1;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_kind         = out_kind_reg;
    assign out_address      = out_address_reg;
    assign out_length       = out_length_reg;
    assign out_position     = out_position_reg;
    assign out_payload_byte = out_payload_reg;
    assign out_last         = out_last_reg;

endmodule

[rtl/core/crcdf_ctrl.sv]
// ============================================================================
// CRC-16 packet deframer controller
// Frame phase state machine that drives the datapath commands.
// ============================================================================
module crcdf_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  crcdf_pkg::sts_t sts,
    output crcdf_pkg::cmd_t cmd
);
    import crcdf_pkg::*;

    `include "crc16_packet_deframer_top_assert.svh"

    localparam logic [3:0] ST_H1   = 4'd0;
    localparam logic [3:0] ST_H2   = 4'd1;
    localparam logic [3:0] ST_ADDR = 4'd2;
    localparam logic [3:0] ST_LEN  = 4'd3;
    localparam logic [3:0] ST_DATA = 4'd4;
    localparam logic [3:0] ST_CRC1 = 4'd5;
    localparam logic [3:0] ST_CRC2 = 4'd6;
    localparam logic [3:0] ST_RD   = 4'd7;
    localparam logic [3:0] ST_LD   = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       acc;

    assign acc = in_valid && in_ready;

    always_comb
    begin
        unique case (state_reg)
            ST_LEN, ST_CRC1, ST_CRC2: in_ready = !sts.out_busy;
            ST_RD, ST_LD:             in_ready = 1'b0;
            default:                  in_ready = 1'b1;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_kind = KIND_DATA;
        unique case (state_reg)
            ST_H2:
            begin
                if (acc)
                begin
                    priority if (sts.hit_second)
                        state_next = ST_ADDR;
                    else if (sts.hit_first)
                        state_next = ST_H2;
                    else
                        state_next = ST_H1;
                end
            end
            ST_ADDR:
            begin
                if (acc)
                begin
                    cmd.addr_load = 1'b1;
                    state_next    = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (acc)
                begin
                    if (sts.len_too_long)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = KIND_TOO_LONG;
                        state_next   = ST_H1;
                    end
                    else
                    begin
                        cmd.len_load = 1'b1;
                        state_next   = sts.len_zero ? ST_CRC1 : ST_DATA;
                    end
                end
            end
            ST_DATA:
            begin
                if (acc)
                begin
                    cmd.data_store = 1'b1;
                    if (sts.data_done)
                    begin
                        state_next = ST_CRC1;
                    end
                end
            end
            ST_CRC1:
            begin
                if (acc)
                begin
                    if (sts.crc_lo_ok)
                    begin
                        state_next = ST_CRC2;
                    end
                    else
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = KIND_CRC_ERR;
                        state_next   = ST_H1;
                    end
                end
            end
            ST_CRC2:
            begin
                if (acc)
                begin
                    priority if (!sts.crc_hi_ok)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = KIND_CRC_ERR;
                        state_next   = ST_H1;
                    end
                    else if (sts.pkt_len_zero)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = KIND_EMPTY;
                        state_next   = ST_H1;
                    end
                    else
                    begin
                        cmd.rd_clear = 1'b1;
                        state_next   = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_LD;
            end
            ST_LD:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_from_ram = 1'b1;
                    if (sts.rd_last)
                    begin
                        state_next = ST_H1;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                        state_next  = ST_RD;
                    end
                end
            end
            default:
            begin
                if (acc)
                begin
                    state_next = sts.hit_first ? ST_H2 : ST_H1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_H1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `CRCDF_ASSERT_SAME(a_no_rx_in_readout, (state_reg == ST_RD || state_reg == ST_LD), !in_ready, "Byte taken during payload readout")
    `CRCDF_ASSERT_SAME(a_load_needs_room, cmd.out_load, sts.out_free, "Result loaded over an unsent result")
    `CRCDF_ASSERT_NEXT(a_read_then_load, (state_reg == ST_RD), (state_reg == ST_LD), "Store read not followed by result load")
    `CRCDF_ASSERT_SAME(a_store_only_in_data, cmd.data_store, (state_reg == ST_DATA && in_valid), "Payload stored outside the data phase")

endmodule
